>>> rtl/core/pag_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pag_pkg;

  localparam int MAX_NODES   = 1024;
  localparam int SAMPLE_BITS = 16;
  localparam int NODE_W      = $clog2(MAX_NODES);
  localparam int SRC_W       = NODE_W + 1;
  localparam int CFG_W       = 11;
  localparam int LIM_W       = (SRC_W > CFG_W) ? SRC_W : CFG_W;
  localparam int DEG_W       = 11;
  localparam int TOT_W       = 20;
  localparam int EDGE_W      = 10;
  localparam int PROD_W      = SAMPLE_BITS + TOT_W;
  localparam int CFG_RESET   = 1024;

  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = FIFO_PTR_W + 1;

  localparam logic [DEG_W-1:0] DEG_MAX = '1;
  localparam logic [TOT_W-1:0] TOT_MAX = '1;

  typedef enum logic [1:0] {
    KIND_FINISHED,
    KIND_SEED,
    KIND_CANDIDATE
  } kind_t;

  typedef struct packed {
    logic                   valid;
    kind_t                  kind;
    logic                   adv;
    logic [SAMPLE_BITS-1:0] sample;
    logic [SRC_W-1:0]       src;
    logic [NODE_W-1:0]      old_src;
    logic [NODE_W-1:0]      tgt;
  } item_t;

  typedef struct packed {
    logic              en;
    logic [NODE_W-1:0] addr;
    logic [DEG_W-1:0]  data;
  } deg_wr_t;

  typedef struct packed {
    logic              edge_valid;
    logic [EDGE_W-1:0] source;
    logic [EDGE_W-1:0] target;
    logic              finished;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/core/pag_degree_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module pag_degree_ram (
  input  wire logic                                      clk,
  input  wire pag_pkg::deg_wr_t                          wr_i,
  input  wire logic                                      rd_en_i,
  input  wire logic [pag_pkg::NODE_W-1:0]                rd_addr_i,
  output logic      [pag_pkg::DEG_W-1:0]                 rd_data_o
);
  import pag_pkg::*;

  logic [DEG_W-1:0] mem_r [MAX_NODES];
  logic [DEG_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_i.en) begin
      mem_r[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en_i) begin
      rd_data_r <= mem_r[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_r;

endmodule
`default_nettype wire

>>> rtl/core/pag_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module pag_ctrl (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [pag_pkg::CFG_W-1:0]            cfg_wr_data,
  input  wire logic                                 in_fire_i,
  input  wire logic [pag_pkg::SAMPLE_BITS-1:0]      sample_i,
  output logic                                      rd_en_o,
  output logic      [pag_pkg::NODE_W-1:0]           rd_addr_o,
  output pag_pkg::item_t                            s1_o
);
  import pag_pkg::*;

  logic [CFG_W-1:0]  node_count_r;
  logic [SRC_W-1:0]  src_r, src_nxt;
  logic [NODE_W-1:0] tgt_r, tgt_nxt;
  logic              seed_r, seed_nxt;
  item_t             s1_r, item_nxt;

  logic [LIM_W-1:0]  cnt_ext;
  logic [LIM_W-1:0]  limit;
  logic [SRC_W-1:0]  src_inc;
  logic [SRC_W-1:0]  tgt_inc;

  assign cnt_ext = LIM_W'(node_count_r);
  assign limit   = (cnt_ext > LIM_W'(MAX_NODES)) ? LIM_W'(MAX_NODES) : cnt_ext;
  assign src_inc = src_r + SRC_W'(1);
  assign tgt_inc = SRC_W'(tgt_r) + SRC_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= CFG_W'(CFG_RESET);
    end else if (cfg_wr_en) begin
      node_count_r <= cfg_wr_data;
    end
  end

  always_comb begin
    src_nxt          = src_r;
    tgt_nxt          = tgt_r;
    seed_nxt         = seed_r;
    rd_en_o          = 1'b0;
    item_nxt.valid   = in_fire_i;
    item_nxt.kind    = KIND_FINISHED;
    item_nxt.adv     = 1'b0;
    item_nxt.sample  = sample_i;
    item_nxt.src     = src_r;
    item_nxt.old_src = NODE_W'(src_r);
    item_nxt.tgt     = tgt_r;
    if (in_fire_i) begin
      if (LIM_W'(src_r) >= limit) begin
        item_nxt.kind = KIND_FINISHED;
      end else if (!seed_r) begin
        seed_nxt      = 1'b1;
        item_nxt.kind = KIND_SEED;
      end else if (tgt_inc >= src_r) begin
        tgt_nxt      = '0;
        src_nxt      = src_inc;
        item_nxt.adv = 1'b1;
        item_nxt.src = src_inc;
        item_nxt.tgt = '0;
        if (LIM_W'(src_inc) >= limit) begin
          item_nxt.kind = KIND_FINISHED;
        end else begin
          item_nxt.kind = KIND_CANDIDATE;
          rd_en_o       = 1'b1;
        end
      end else begin
        tgt_nxt       = NODE_W'(tgt_inc);
        item_nxt.tgt  = NODE_W'(tgt_inc);
        item_nxt.kind = KIND_CANDIDATE;
        rd_en_o       = 1'b1;
      end
    end
  end

  assign rd_addr_o = item_nxt.tgt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r  <= SRC_W'(1);
      tgt_r  <= '0;
      seed_r <= 1'b0;
      s1_r   <= '0;
    end else begin
      src_r  <= src_nxt;
      tgt_r  <= tgt_nxt;
      seed_r <= seed_nxt;
      s1_r   <= item_nxt;
    end
  end

  assign s1_o = s1_r;

endmodule
`default_nettype wire

>>> rtl/core/pag_update.sv
`timescale 1ns / 1ps
`default_nettype none
module pag_update (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire pag_pkg::item_t                s1_i,
  input  wire logic [pag_pkg::DEG_W-1:0]     rd_data_i,
  output pag_pkg::deg_wr_t                   wr_o,
  output pag_pkg::result_t                   res_o,
  output logic                               res_push_o,
  output logic                               pend_valid_o
);
  import pag_pkg::*;

  logic [TOT_W-1:0]  total_r, total_nxt;
  logic [DEG_W-1:0]  src_deg_r, src_deg_nxt;
  deg_wr_t           wr_q_r;
  deg_wr_t           pend_r, pend_nxt;
  deg_wr_t           wr;
  deg_wr_t           wb_new;

  logic [DEG_W-1:0]  deg_fwd;
  logic [DEG_W-1:0]  deg_cur;
  logic [DEG_W-1:0]  deg_inc;
  logic [PROD_W-1:0] product;
  logic              is_cand;
  logic              is_seed;
  logic              hit;

  // degree seen by this item: memory, then last port write, then parked write-back
  always_comb begin
    deg_fwd = rd_data_i;
    if (wr_q_r.en && (wr_q_r.addr == s1_i.tgt)) begin
      deg_fwd = wr_q_r.data;
    end
    if (pend_r.en && (pend_r.addr == s1_i.tgt)) begin
      deg_fwd = pend_r.data;
    end
  end

  assign is_cand = s1_i.valid && (s1_i.kind == KIND_CANDIDATE);
  assign is_seed = s1_i.valid && (s1_i.kind == KIND_SEED);
  assign deg_cur = is_seed ? '0 : deg_fwd;
  assign deg_inc = (deg_cur == DEG_MAX) ? deg_cur : deg_cur + DEG_W'(1);
  assign product = PROD_W'(s1_i.sample) * PROD_W'(total_r);
  assign hit     = is_seed ||
                   (is_cand && (product[PROD_W-1:SAMPLE_BITS] < TOT_W'(deg_cur)));

  always_comb begin
    wb_new.en   = s1_i.valid && s1_i.adv;
    wb_new.addr = s1_i.old_src;
    wb_new.data = src_deg_r;

    wr          = '0;
    pend_nxt    = pend_r;
    if (hit) begin
      wr.en   = 1'b1;
      wr.addr = s1_i.tgt;
      wr.data = deg_inc;
      if (pend_r.en && (pend_r.addr == s1_i.tgt)) begin
        pend_nxt.en = 1'b0;
      end
      if (wb_new.en) begin
        pend_nxt = wb_new;
      end
    end else if (wb_new.en) begin
      wr = wb_new;
    end else if (pend_r.en) begin
      wr          = pend_r;
      pend_nxt.en = 1'b0;
    end
  end

  always_comb begin
    if (wb_new.en) begin
      src_deg_nxt = hit ? DEG_W'(1) : '0;
    end else if (hit) begin
      src_deg_nxt = (src_deg_r == DEG_MAX) ? src_deg_r : src_deg_r + DEG_W'(1);
    end else begin
      src_deg_nxt = src_deg_r;
    end
    if (hit) begin
      total_nxt = (total_r > TOT_MAX - TOT_W'(2)) ? TOT_MAX : total_r + TOT_W'(2);
    end else begin
      total_nxt = total_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r   <= '0;
      src_deg_r <= '0;
      wr_q_r    <= '0;
      pend_r    <= '0;
    end else begin
      total_r   <= total_nxt;
      src_deg_r <= src_deg_nxt;
      wr_q_r    <= wr;
      pend_r    <= pend_nxt;
    end
  end

  assign wr_o             = wr;
  assign res_push_o       = s1_i.valid;
  assign res_o.edge_valid = hit;
  assign res_o.source     = hit ? EDGE_W'(s1_i.src) : '0;
  assign res_o.target     = hit ? EDGE_W'(s1_i.tgt) : '0;
  assign res_o.finished   = s1_i.valid && (s1_i.kind == KIND_FINISHED);
  assign pend_valid_o     = pend_r.en;

  a_adv_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
    s1_i.valid && s1_i.adv |-> s1_i.tgt == '0)
    else $error("advancing item has nonzero target");

  a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
    hit && is_cand |-> SRC_W'(s1_i.tgt) < s1_i.src)
    else $error("accepted edge with target not below source");

  a_single_writeback: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r.en |-> !(s1_i.valid && s1_i.adv))
    else $error("second write-back while one is parked");

  a_pend_drains: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r.en && !s1_i.valid |=> !pend_r.en)
    else $error("parked write-back not drained on idle port");

  a_total_even: assert property (@(posedge clk) disable iff (!rst_n)
    (total_r[0] == 1'b0) || (total_r == TOT_MAX))
    else $error("total degree odd below saturation");

endmodule
`default_nettype wire

>>> rtl/core/pag_out_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module pag_out_fifo (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              push_i,
  input  wire pag_pkg::result_t                  din_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output pag_pkg::result_t                       dout_o,
  output logic      [pag_pkg::FIFO_CNT_W-1:0]    count_o
);
  import pag_pkg::*;

  result_t               mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  pop;

  assign out_valid_o = (cnt_r != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign dout_o      = mem_r[rd_ptr_r];
  assign count_o     = cnt_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push_i && !pop) begin
      cnt_nxt = cnt_r + FIFO_CNT_W'(1);
    end else if (!push_i && pop) begin
      cnt_nxt = cnt_r - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= din_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/preferential_attachment_edge_gen.sv
`timescale 1ns / 1ps
`default_nettype none
// Preferential-attachment edge stream generator. Each input transfer yields one result
// transfer, which passes the item register and then the result queue. Items are taken
// one per cycle while the result side keeps up; apart from a full result queue the only
// bubbles come when the source node advances: its degree, kept in a register while it is
// the source, is written back through the single write port of the degree memory, and
// input is held until that write has gone out. Degree reads and the acceptance multiply
// sit in one pipeline stage after the synchronous memory read, with forwarding of the
// last write and of a parked write-back. No clearing pass follows reset: every entry
// below the current source is written before it is read.
module preferential_attachment_edge_gen (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [pag_pkg::CFG_W-1:0]         cfg_wr_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [pag_pkg::SAMPLE_BITS-1:0]   in_random_sample,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_edge_valid,
  output logic      [pag_pkg::EDGE_W-1:0]        out_edge_source,
  output logic      [pag_pkg::EDGE_W-1:0]        out_edge_target,
  output logic                                   out_finished
);
  import pag_pkg::*;

  logic                  in_fire;
  logic                  rd_en;
  logic [NODE_W-1:0]     rd_addr;
  logic [DEG_W-1:0]      rd_data;
  item_t                 s1;
  deg_wr_t               deg_wr;
  result_t               res;
  result_t               dout;
  logic                  res_push;
  logic                  pend_valid;
  logic [FIFO_CNT_W-1:0] fifo_cnt;
  logic [FIFO_CNT_W:0]   occ;

  // room for the item in flight plus this one
  assign occ      = (FIFO_CNT_W + 1)'(fifo_cnt) + (FIFO_CNT_W + 1)'(s1.valid);
  assign in_ready = !pend_valid && (occ < (FIFO_CNT_W + 1)'(FIFO_DEPTH));
  assign in_fire  = in_valid && in_ready;

  pag_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_fire_i   (in_fire),
    .sample_i    (in_random_sample),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .s1_o        (s1)
  );

  pag_degree_ram u_ram (
    .clk       (clk),
    .wr_i      (deg_wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  pag_update u_update (
    .clk          (clk),
    .rst_n        (rst_n),
    .s1_i         (s1),
    .rd_data_i    (rd_data),
    .wr_o         (deg_wr),
    .res_o        (res),
    .res_push_o   (res_push),
    .pend_valid_o (pend_valid)
  );

  pag_out_fifo u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (res_push),
    .din_i       (res),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .dout_o      (dout),
    .count_o     (fifo_cnt)
  );

  assign out_edge_valid  = dout.edge_valid;
  assign out_edge_source = dout.source;
  assign out_edge_target = dout.target;
  assign out_finished    = dout.finished;

endmodule
`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps
module tb;
  import pag_pkg::*;

  localparam int GAP_MAX        = 17;
  localparam int LONG_HOLD      = 120;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PRINT_CAP      = 40;
  localparam int PHASE_ITEMS    = 60;

  logic                   clk              = 1'b0;
  logic                   rst_n            = 1'b0;
  logic                   cfg_wr_en        = 1'b0;
  logic [CFG_W-1:0]       cfg_wr_data      = '0;
  logic                   in_valid         = 1'b0;
  logic                   in_ready;
  logic [SAMPLE_BITS-1:0] in_random_sample = '0;
  logic                   out_valid;
  logic                   out_ready        = 1'b0;
  logic                   out_edge_valid;
  logic [EDGE_W-1:0]      out_edge_source;
  logic [EDGE_W-1:0]      out_edge_target;
  logic                   out_finished;

  // graph state as the block should hold it
  logic [CFG_W-1:0]       node_count_q;
  logic [DEG_W-1:0]       degree_q [MAX_NODES];
  logic [TOT_W-1:0]       total_q;
  logic [SRC_W-1:0]       source_q;
  logic [NODE_W-1:0]      target_q;
  logic                   seeded_q;

  result_t                pending_edges [$];
  result_t                oldest_edge;
  logic [SAMPLE_BITS-1:0] sample_queue [$];

  int error_count  = 0;
  int gap_limit    = GAP_MAX;
  int gap_left     = 0;
  int stall_left   = 0;
  int hold_left    = 0;
  int results_seen = 0;
  int ready_wait   = 0;
  int quiet_cycles = 0;

  always #4 clk = ~clk;

  preferential_attachment_edge_gen i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_random_sample (in_random_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_edge_valid   (out_edge_valid),
    .out_edge_source  (out_edge_source),
    .out_edge_target  (out_edge_target),
    .out_finished     (out_finished)
  );

  task automatic report_mismatch(input string what, input int got, input int want);
    if (error_count < PRINT_CAP) begin
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    end
    error_count++;
  endtask

  task automatic add_edge(input logic [NODE_W-1:0] src, input logic [NODE_W-1:0] dst);
    if (degree_q[src] != DEG_MAX) degree_q[src] = degree_q[src] + 1'b1;
    if (degree_q[dst] != DEG_MAX) degree_q[dst] = degree_q[dst] + 1'b1;
    total_q = (total_q > TOT_MAX - 2) ? TOT_MAX : total_q + TOT_W'(2);
  endtask

  task automatic attach_step(input logic [SAMPLE_BITS-1:0] sample);
    logic [CFG_W-1:0]  lim;
    logic [PROD_W-1:0] lhs;
    logic [PROD_W-1:0] rhs;
    result_t           r;
    lim = (node_count_q > MAX_NODES) ? CFG_W'(MAX_NODES) : node_count_q;
    r = '0;
    if (source_q >= lim) begin
      r.finished = 1'b1;
    end else if (!seeded_q) begin
      seeded_q = 1'b1;
      add_edge(source_q[NODE_W-1:0], target_q);
      r.edge_valid = 1'b1;
      r.source     = source_q[EDGE_W-1:0];
      r.target     = target_q;
    end else begin
      target_q = target_q + 1'b1;
      if ({1'b0, target_q} >= source_q) begin
        target_q = '0;
        source_q = source_q + 1'b1;
        if (source_q >= lim) r.finished = 1'b1;
      end
      if (!r.finished) begin
        lhs = PROD_W'(sample) * PROD_W'(total_q);
        rhs = PROD_W'(degree_q[target_q]) << SAMPLE_BITS;
        if (lhs < rhs) begin
          add_edge(source_q[NODE_W-1:0], target_q);
          r.edge_valid = 1'b1;
          r.source     = source_q[EDGE_W-1:0];
          r.target     = target_q;
        end
      end
    end
    pending_edges.insert(pending_edges.size(), r);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (sample_queue.size() != 0) begin
        in_valid         <= 1'b1;
        in_random_sample <= sample_queue.pop_front();
        gap_left         <= $urandom_range(0, gap_limit);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver with per-transfer stalls and two long hold-offs
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready    <= 1'b0;
      stall_left   <= 0;
      hold_left    <= 0;
      results_seen <= 0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (results_seen == 120 || results_seen == 380) begin
        hold_left  <= LONG_HOLD;
        stall_left <= 0;
        out_ready  <= 1'b0;
      end else begin
        ready_wait = $urandom_range(0, gap_limit);
        stall_left <= ready_wait;
        out_ready  <= (ready_wait == 0);
      end
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) attach_step(in_random_sample);
      if (out_valid && out_ready) begin
        if (pending_edges.size() == 0) begin
          report_mismatch("unexpected transfer", 1, 0);
        end else begin
          oldest_edge = pending_edges.pop_front();
          if (out_edge_valid !== oldest_edge.edge_valid)
            report_mismatch("edge_valid", out_edge_valid, oldest_edge.edge_valid);
          if (out_edge_source !== oldest_edge.source)
            report_mismatch("edge_source", out_edge_source, oldest_edge.source);
          if (out_edge_target !== oldest_edge.target)
            report_mismatch("edge_target", out_edge_target, oldest_edge.target);
          if (out_finished !== oldest_edge.finished)
            report_mismatch("finished", out_finished, oldest_edge.finished);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("[preferential_attachment_edge_gen] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_node_count(input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    node_count_q = value;
  endtask

  task automatic wait_drained;
    do @(negedge clk);
    while (sample_queue.size() != 0 || in_valid || pending_edges.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] count,
                           input logic [SAMPLE_BITS-1:0] items [$]);
    set_node_count(count);
    @(negedge clk);
    foreach (items[k]) sample_queue.insert(sample_queue.size(), items[k]);
    wait_drained();
  endtask

  initial begin
    logic [SAMPLE_BITS-1:0] batch [$];
    logic [SAMPLE_BITS-1:0] s;
    logic [CFG_W-1:0]       count_pick;
    int                     pick;
    node_count_q = CFG_W'(CFG_RESET);
    foreach (degree_q[k]) degree_q[k] = '0;
    total_q  = '0;
    source_q = SRC_W'(1);
    target_q = '0;
    seeded_q = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // no nodes, one node, the seed pair, resume after finishing, count above the table
    run_phase(CFG_W'(0), '{16'h0000, 16'hFFFF, 16'h1234});
    run_phase(CFG_W'(1), '{16'hFFFF, 16'h0000});
    run_phase(CFG_W'(2), '{16'hFFFF, 16'h0000, 16'h0000});
    run_phase(CFG_W'(5), '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000,
                           16'h0000, 16'h0001, 16'h0000, 16'hFFFF, 16'h0000});
    run_phase(CFG_W'(2047), '{16'h0000, 16'hFFFF, 16'h8000, 16'h0000});

    for (int p = 0; p < 8; p++) begin
      gap_limit = (p == 2 || p == 5) ? 0 : GAP_MAX;
      case (p)
        1: count_pick = CFG_W'(MAX_NODES);
        3: count_pick = source_q + CFG_W'($urandom_range(1, 3));
        4: count_pick = CFG_W'($urandom_range(0, 2047));
        6: count_pick = CFG_W'(2047);
        default: count_pick = CFG_W'($urandom_range(source_q + 8, MAX_NODES));
      endcase
      batch.delete();
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(0, 9);
        if (pick < 3) s = SAMPLE_BITS'($urandom_range(0, 2047));
        else if (pick == 3) s = ($urandom_range(0, 1) != 0) ? '1 : '0;
        else s = SAMPLE_BITS'($urandom);
        batch.insert(batch.size(), s);
      end
      run_phase(count_pick, batch);
    end

    if (error_count == 0) begin
      $display("[preferential_attachment_edge_gen] OK");
    end else begin
      $display("[preferential_attachment_edge_gen] ERROR");
    end
    $finish;
  end

endmodule
